// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/cpbc_pkg.sv
// Package for the cartridge protection bank controller: types, constants, tables.
// No dependencies.
`default_nettype none
package cpbc_pkg;
    localparam int BANK_TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(BANK_TABLE_ENTRIES);

    typedef enum logic [1:0] {
        SRC_OPEN = 2'd0,
        SRC_DATA = 2'd1,
        SRC_ROM  = 2'd2
    } src_t;

    localparam logic CFG_BOARD_TYPE = 1'b0;
    localparam logic CFG_ROM_WORDS  = 1'b1;

    localparam logic [15:0] PRESENCE_VALUE = 16'h9A37;
    localparam logic [15:0] RANDOM_SEED    = 16'h2345;
    localparam logic [23:0] BANK_BASE_RST  = 24'h100000;
    localparam logic [23:0] WINDOW_BASE    = 24'h200000;
    localparam logic [22:0] PRESENCE_WADDR = 23'h17F223; // 0x2FE446 >> 1

    typedef struct packed {
        logic        cmd;
        logic [23:0] address;
        logic [15:0] data;
        logic        upper_lane;
        logic        lower_lane;
    } item_t;

    typedef struct packed {
        logic [1:0]  source;
        logic [15:0] read_data;
        logic [22:0] rom_word_address;
        logic        bank_written;
    } result_t;

    typedef struct packed {
        logic        bank_we;
        logic [23:0] bank_base;
        logic [15:0] bank_select;
        logic        rand_step;
    } upd_t;

    function automatic logic [2:0] board_kind(input logic [2:0] bt);
        return (bt == 3'd7) ? 3'd6 : bt;
    endfunction

    function automatic logic [3:0] swap_bit(input logic [2:0] kind, input logic [2:0] i);
        logic [3:0] b;
        b = 4'd0;
        case (kind)
            3'd1: case (i) 3'd0: b = 4'd15; 3'd1: b = 4'd14; 3'd2: b = 4'd7;
                      3'd3: b = 4'd3; 3'd4: b = 4'd10; default: b = 4'd5; endcase
            3'd2: case (i) 3'd0: b = 4'd5; 3'd1: b = 4'd9; 3'd2: b = 4'd7;
                      3'd3: b = 4'd6; 3'd4: b = 4'd14; default: b = 4'd12; endcase
            3'd3: case (i) 3'd0: b = 4'd4; 3'd1: b = 4'd8; 3'd2: b = 4'd14;
                      3'd3: b = 4'd2; 3'd4: b = 4'd11; default: b = 4'd13; endcase
            3'd4: case (i) 3'd0: b = 4'd14; 3'd1: b = 4'd12; 3'd2: b = 4'd15;
                      3'd3: b = 4'd6; 3'd4: b = 4'd3; default: b = 4'd9; endcase
            3'd5: case (i) 3'd0: b = 4'd15; 3'd1: b = 4'd3; 3'd2: b = 4'd1;
                      3'd3: b = 4'd6; 3'd4: b = 4'd12; default: b = 4'd11; endcase
            default: case (i) 3'd0: b = 4'd14; 3'd1: b = 4'd6; 3'd2: b = 4'd8;
                      3'd3: b = 4'd10; 3'd4: b = 4'd12; default: b = 4'd5; endcase
        endcase
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] swap_index(input logic [15:0] sel,
                                                    input logic [2:0] kind);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < IDX_W; i++)
            r[IDX_W-1-i] = sel[swap_bit(kind, 3'(i))];
        return r;
    endfunction

    // Per-board bank offset table; indexes past a board's list give zero.
    function automatic logic [23:0] offset_lookup(input logic [2:0] kind,
                                                  input logic [IDX_W-1:0] idx);
        logic [23:0] o;
        o = 24'h0;
        case (kind)
            3'd0: case (idx)
                6'd1: o=24'h100000; 6'd2: o=24'h200000; 6'd3: o=24'h300000;
                6'd4: o=24'h3cc000; 6'd5: o=24'h4cc000; 6'd6: o=24'h3f2000;
                6'd7: o=24'h4f2000; 6'd8: o=24'h407800; 6'd9: o=24'h507800;
                6'd10: o=24'h40d000; 6'd11: o=24'h50d000; 6'd12: o=24'h417800;
                6'd13: o=24'h517800; 6'd14: o=24'h420800; 6'd15: o=24'h520800;
                6'd16: o=24'h424800; 6'd17: o=24'h524800; 6'd18: o=24'h429000;
                6'd19: o=24'h529000; 6'd20: o=24'h42e800; 6'd21: o=24'h52e800;
                6'd22: o=24'h431800; 6'd23: o=24'h531800; 6'd24: o=24'h54d000;
                6'd25: o=24'h551000; 6'd26: o=24'h567000; 6'd27: o=24'h592800;
                6'd28: o=24'h588800; 6'd29: o=24'h581800; 6'd30: o=24'h599800;
                6'd31: o=24'h594800; 6'd32: o=24'h598000;
                default: o=24'h0; endcase
            3'd1: case (idx)
                6'd1: o=24'h100000; 6'd2: o=24'h200000; 6'd3: o=24'h300000;
                6'd4: o=24'h3f7800; 6'd5: o=24'h4f7800; 6'd6: o=24'h3ff800;
                6'd7: o=24'h4ff800; 6'd8: o=24'h407800; 6'd9: o=24'h507800;
                6'd10: o=24'h40f800; 6'd11: o=24'h50f800; 6'd12: o=24'h416800;
                6'd13: o=24'h516800; 6'd14: o=24'h41d800; 6'd15: o=24'h51d800;
                6'd16: o=24'h424000; 6'd17: o=24'h524000; 6'd18: o=24'h523800;
                6'd19: o=24'h623800; 6'd20: o=24'h526000; 6'd21: o=24'h626000;
                6'd22: o=24'h528000; 6'd23: o=24'h628000; 6'd24: o=24'h52a000;
                6'd25: o=24'h62a000; 6'd26: o=24'h52b800; 6'd27: o=24'h62b800;
                6'd28: o=24'h52d000; 6'd29: o=24'h62d000; 6'd30: o=24'h52e800;
                6'd31: o=24'h62e800; 6'd32: o=24'h618000; 6'd33: o=24'h619000;
                6'd34: o=24'h61a000; 6'd35: o=24'h61a800;
                default: o=24'h0; endcase
            3'd2, 3'd3: case (idx)
                6'd1: o=24'h100000; 6'd2: o=24'h200000; 6'd3: o=24'h300000;
                6'd4: o=24'h280000; 6'd5: o=24'h380000; 6'd6: o=24'h2d0000;
                6'd7: o=24'h3d0000;
                6'd8: o=(kind==3'd2)?24'h2f0000:24'h2c8000;
                6'd9: o=(kind==3'd2)?24'h3f0000:24'h3c8000;
                6'd10: o=24'h400000; 6'd11: o=24'h500000; 6'd12: o=24'h420000;
                6'd13: o=24'h520000; 6'd14: o=24'h440000; 6'd15: o=24'h540000;
                6'd16: o=(kind==3'd2)?24'h498000:24'h598000;
                6'd17: o=(kind==3'd2)?24'h598000:24'h698000;
                6'd18: o=(kind==3'd2)?24'h4a0000:24'h5a0000;
                6'd19: o=(kind==3'd2)?24'h5a0000:24'h6a0000;
                6'd20: o=(kind==3'd2)?24'h4a8000:24'h5a8000;
                6'd21: o=(kind==3'd2)?24'h5a8000:24'h6a8000;
                6'd22: o=(kind==3'd2)?24'h4b0000:24'h5b0000;
                6'd23: o=(kind==3'd2)?24'h5b0000:24'h6b0000;
                6'd24: o=(kind==3'd2)?24'h4b8000:24'h5b8000;
                6'd25: o=(kind==3'd2)?24'h5b8000:24'h6b8000;
                6'd26: o=(kind==3'd2)?24'h4c0000:24'h5c0000;
                6'd27: o=(kind==3'd2)?24'h5c0000:24'h6c0000;
                6'd28: o=(kind==3'd2)?24'h4c8000:24'h5c8000;
                6'd29: o=(kind==3'd2)?24'h5c8000:24'h6c8000;
                6'd30: o=(kind==3'd2)?24'h4d0000:24'h5d0000;
                6'd31: o=(kind==3'd2)?24'h5d0000:24'h6d0000;
                6'd32: o=24'h458000; 6'd33: o=24'h558000; 6'd34: o=24'h460000;
                6'd35: o=24'h560000; 6'd36: o=24'h468000; 6'd37: o=24'h568000;
                6'd38: o=24'h470000; 6'd39: o=24'h570000; 6'd40: o=24'h478000;
                6'd41: o=24'h578000; 6'd42: o=24'h480000; 6'd43: o=24'h580000;
                6'd44: o=24'h488000; 6'd45: o=24'h588000; 6'd46: o=24'h490000;
                6'd47: o=24'h590000;
                6'd48: o=(kind==3'd2)?24'h5d0000:24'h5d8000;
                6'd49: o=(kind==3'd2)?24'h5d8000:24'h6d8000;
                6'd50: o=(kind==3'd2)?24'h5e0000:24'h5e0000;
                6'd51: o=(kind==3'd2)?24'h5e8000:24'h6e0000;
                6'd52: o=(kind==3'd2)?24'h5f0000:24'h5e8000;
                6'd53: o=(kind==3'd2)?24'h5f8000:24'h6e8000;
                6'd54: o=(kind==3'd2)?24'h600000:24'h6e8000;
                default: o=24'h0; endcase
            3'd4, 3'd5: case (idx)
                6'd1: o=(kind==3'd4)?24'h020000:24'h030000;
                6'd2: o=24'h040000;
                6'd3: o=24'h070000^((kind==3'd4)?24'h010000:24'h0);
                6'd4: o=(kind==3'd4)?24'h070000:24'h080000;
                6'd5: o=(kind==3'd4)?24'h090000:24'h0a0000;
                6'd6: o=(kind==3'd4)?24'h0b0000:24'h0c0000;
                6'd7: o=(kind==3'd4)?24'h0d0000:24'h0e0000;
                6'd8: o=(kind==3'd4)?24'h0e0000:24'h0f0000;
                6'd9: o=(kind==3'd4)?24'h0f0000:24'h100000;
                6'd10: o=(kind==3'd4)?24'h120000:24'h130000;
                6'd11: o=(kind==3'd4)?24'h130000:24'h140000;
                6'd12: o=(kind==3'd4)?24'h140000:24'h150000;
                6'd13: o=(kind==3'd4)?24'h150000:24'h160000;
                6'd14: o=(kind==3'd4)?24'h180000:24'h190000;
                6'd15: o=(kind==3'd4)?24'h190000:24'h1a0000;
                6'd16: o=(kind==3'd4)?24'h1a0000:24'h1b0000;
                6'd17: o=(kind==3'd4)?24'h1b0000:24'h1c0000;
                6'd18: o=(kind==3'd4)?24'h1e0000:24'h1f0000;
                6'd19: o=(kind==3'd4)?24'h1f0000:24'h200000;
                6'd20: o=(kind==3'd4)?24'h200000:24'h210000;
                6'd21: o=(kind==3'd4)?24'h210000:24'h220000;
                6'd22: o=(kind==3'd4)?24'h240000:24'h250000;
                6'd23: o=(kind==3'd4)?24'h250000:24'h260000;
                6'd24: o=(kind==3'd4)?24'h260000:24'h270000;
                6'd25: o=(kind==3'd4)?24'h270000:24'h280000;
                6'd26: o=(kind==3'd4)?24'h2a0000:24'h2b0000;
                6'd27: o=(kind==3'd4)?24'h2b0000:24'h2c0000;
                6'd28: o=(kind==3'd4)?24'h2c0000:24'h2d0000;
                6'd29: o=(kind==3'd4)?24'h2d0000:24'h2e0000;
                6'd30: o=(kind==3'd4)?24'h300000:24'h310000;
                6'd31: o=(kind==3'd4)?24'h310000:24'h320000;
                6'd32: o=(kind==3'd4)?24'h320000:24'h330000;
                6'd33: o=(kind==3'd4)?24'h330000:24'h340000;
                6'd34: o=(kind==3'd4)?24'h360000:24'h370000;
                6'd35: o=(kind==3'd4)?24'h370000:24'h380000;
                6'd36: o=(kind==3'd4)?24'h380000:24'h390000;
                6'd37: o=(kind==3'd4)?24'h390000:24'h3a0000;
                6'd38: o=24'h3c0000+((kind==3'd4)?24'h0:24'h010000);
                6'd39: o=24'h3d0000+((kind==3'd4)?24'h0:24'h010000);
                6'd40: o=24'h400000; 6'd41: o=24'h410000; 6'd42: o=24'h440000;
                6'd43: o=24'h450000; 6'd44: o=24'h460000; 6'd45: o=24'h470000;
                6'd46: o=24'h4a0000; 6'd47: o=24'h4b0000; 6'd48: o=24'h4c0000;
                default: o=24'h0; endcase
            default: o = 24'h0;
        endcase
        return o;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/cpbc_decode.sv
// Combinational decode of one registered bus access against the bank state.
// Depends on cpbc_pkg.
`default_nettype none
module cpbc_decode (
    input  wire cpbc_pkg::item_t   item,
    input  wire [2:0]              board_type,
    input  wire [23:0]             rom_words,
    input  wire [23:0]             bank_base,
    input  wire [15:0]             random_shift,
    output cpbc_pkg::result_t      result,
    output cpbc_pkg::upd_t         upd
);
    import cpbc_pkg::*;

    logic [2:0]       kind;
    logic [22:0]      w;
    logic             bank_hit;
    logic             rand_hit;
    logic [15:0]      sel;
    logic [IDX_W-1:0] idx;
    logic [24:0]      phys;

    assign kind = board_kind(board_type);
    assign w    = item.address[23:1];

    always_comb
    begin
        unique case (kind)
            3'd0: bank_hit = (w == 23'h17FFF8);
            3'd1: bank_hit = (w == 23'h17FFF6);
            3'd2, 3'd3: bank_hit = (w == 23'h17FFE0);
            3'd4, 3'd5: bank_hit = (w == 23'h17FFF2);
            default: bank_hit = (w == 23'h17FFF8) || (w == 23'h17FFE0) ||
                                (w == 23'h17FFF2) || (w == 23'h17FFF6);
        endcase
        unique case (kind)
            3'd0, 3'd4, 3'd5: rand_hit = (w == 23'h17FFFC) || (w == 23'h17FFFD);
            3'd1: rand_hit = (w == 23'h17FFEC) || (w == 23'h17FFED);
            3'd2, 3'd3: rand_hit = (w == 23'h17FFE6) || (w == 23'h17FFF8);
            default: rand_hit = (w == 23'h17FFFC) || (w == 23'h17FFFD) ||
                                (w == 23'h17FFEC) || (w == 23'h17FFED) ||
                                (w == 23'h17FFE6);
        endcase
    end

    always_comb
    begin
        if (item.lower_lane && !item.upper_lane)
            sel = {item.data[7:0], item.data[7:0]};
        else if (item.upper_lane && !item.lower_lane)
            sel = {item.data[15:8], item.data[15:8]};
        else
            sel = item.data;
    end

    assign idx  = swap_index(sel, kind);
    assign phys = {1'b0, bank_base} + {1'b0, item.address} - {1'b0, WINDOW_BASE};

    always_comb
    begin
        result = '0;
        upd    = '0;
        upd.bank_select = sel;
        if (kind == 3'd6)
            upd.bank_base = BANK_BASE_RST + {1'b0, idx[2:0], 20'h0};
        else
            upd.bank_base = BANK_BASE_RST + offset_lookup(kind, idx);
        if (item.cmd)
        begin
            upd.bank_we         = bank_hit;
            result.bank_written = bank_hit;
        end
        else if (w == PRESENCE_WADDR)
        begin
            result.source    = SRC_DATA;
            result.read_data = PRESENCE_VALUE;
        end
        else if (rand_hit)
        begin
            result.source    = SRC_DATA;
            result.read_data = random_shift;
            upd.rand_step    = 1'b1;
        end
        else if (item.address[23:20] == 4'h0)
        begin
            result.source           = SRC_ROM;
            result.rom_word_address = w;
        end
        else if (item.address[23:20] == 4'h2 && !bank_hit)
        begin
            if (phys[24:1] < rom_words)
            begin
                result.source           = SRC_ROM;
                result.rom_word_address = phys[23:1];
            end
            else
                result.read_data = item.data;
        end
        else
            result.read_data = item.data;
    end
endmodule
`default_nettype wire

// File: hw/rtl/cartridge_protection_bank_controller_unit.sv
// Top level of the cartridge protection bank controller.
// Depends on cpbc_pkg and cpbc_decode.
//
// Usage:
//  - s_axis_* carries one bus access per beat; tdata from bit 0 up holds
//    address[23:0], data[39:24], upper_lane[40], lower_lane[41];
//    tuser is cmd (0 read, 1 write).
//  - m_axis_* carries one result per accepted access; tdata = source[1:0],
//    read_data[17:2], rom_word_address[40:18], bank_written[41].
//  - cfg_* writes board_type (index 0) or rom_words (index 1); write only
//    while no access is in flight.
//  - Pipeline: an access is registered in the input stage, decoded
//    combinationally, and its result is registered in the output stage,
//    which drives m_axis_tvalid.
//  - Throughput: one access per cycle, set by the single decode stage. The
//    input stage holds when the output register is full and stalled, so a
//    receiver stall backs up into s_axis_tready without losing a beat.
//  - Reset: bank base 0x100000, selector 0, random register 0x2345,
//    board_type generic, rom_words 0; pipeline empty.
`default_nettype none
module cartridge_protection_bank_controller_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,  // address[23:0], data[39:24], upper[40], lower[41]
    input  wire         s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // source[1:0], read_data[17:2], rom_addr[40:18], bw[41]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [23:0] cfg_data
);
    import cpbc_pkg::*;

    item_t       item_reg;
    logic        in_valid_reg;
    result_t     res_reg;
    logic        out_valid_reg;
    logic [2:0]  board_type_reg;
    logic [23:0] rom_words_reg;
    logic [23:0] bank_base_reg;
    logic [15:0] bank_select_reg;
    logic [15:0] random_shift_reg;
    logic [15:0] random_shift_next;
    result_t     res_next;
    upd_t        upd;
    logic        advance;

    // Stage 2 moves when output is empty or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg.bank_written, res_reg.rom_word_address,
                            res_reg.read_data, res_reg.source};

    cpbc_decode u_decode (
        .item         (item_reg),
        .board_type   (board_type_reg),
        .rom_words    (rom_words_reg),
        .bank_base    (bank_base_reg),
        .random_shift (random_shift_reg),
        .result       (res_next),
        .upd          (upd)
    );

    assign random_shift_next = {random_shift_reg[14:0],
        random_shift_reg[2] ^ random_shift_reg[3] ^ random_shift_reg[5] ^
        random_shift_reg[6] ^ random_shift_reg[7] ^ random_shift_reg[11] ^
        random_shift_reg[12] ^ random_shift_reg[15]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            board_type_reg   <= 3'd6;
            rom_words_reg    <= 24'd0;
            bank_base_reg    <= BANK_BASE_RST;
            bank_select_reg  <= 16'd0;
            random_shift_reg <= RANDOM_SEED;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_BOARD_TYPE)
                    board_type_reg <= cfg_data[2:0];
                else
                    rom_words_reg <= cfg_data;
            end
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            // Commit state only when the decoded beat moves to the output.
            if (advance && in_valid_reg)
            begin
                if (upd.bank_we)
                begin
                    bank_base_reg   <= upd.bank_base;
                    bank_select_reg <= upd.bank_select;
                end
                if (upd.rand_step)
                    random_shift_reg <= random_shift_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.cmd        <= s_axis_tuser;
            item_reg.address    <= s_axis_tdata[23:0];
            item_reg.data       <= s_axis_tdata[39:24];
            item_reg.upper_lane <= s_axis_tdata[40];
            item_reg.lower_lane <= s_axis_tdata[41];
        end
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end
endmodule
`default_nettype wire

// File: hw/rtl/cpbc_checker.sv
// Port-level checker for the bank controller, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cpbc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "out held")
    `CHK_IMPL(a_src, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad source")
    `CHK_IMPL(a_rom, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] == 2'd2, m_axis_tdata[17:2] == 16'd0, "rom data")
    `CHK_IMPL(a_bw, clk, rst_n, m_axis_tvalid && m_axis_tdata[41], m_axis_tdata[1:0] == 2'd0, "bw source")
endmodule
bind cartridge_protection_bank_controller_unit cpbc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire
